// File: design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
        else $error("property failed");
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop)
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond)
`endif
`endif

// File: design/stt_pkg.sv
// shared constants and types of the sparse triplet transpose unit
`timescale 1ns / 1ps
package stt_pkg;
    localparam int MAX_ENTRIES = 64;
    localparam int MAX_DIM     = 64;
    localparam int VALUE_BITS  = 32;
    localparam int IDX_W       = 6;
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic REG_NUM_COLS = 1'b0;
    localparam logic REG_NUM_ROWS = 1'b1;

    typedef struct packed {
        logic                         vld;
        logic [IDX_W-1:0]             col;
        logic [IDX_W-1:0]             row;
        logic signed [VALUE_BITS-1:0] val;
    } stt_entry_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } stt_ctrl_t;
endpackage

// File: design/stt_cell.sv
// one cell of the sorted insertion chain
`timescale 1ns / 1ps
module stt_cell
    import stt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stt_ctrl_t  ctl,
    input  stt_entry_t new_entry,
    input  stt_entry_t prev_entry,
    input  logic       prev_gt,
    input  stt_entry_t next_entry,
    output stt_entry_t entry,
    output logic       gt
);
    stt_entry_t entry_reg;
    stt_entry_t entry_next;

    // empty cells sort after everything, equal columns keep arrival order
    assign gt    = !entry_reg.vld || (entry_reg.col > new_entry.col);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift)
        begin
            entry_next = next_entry;
        end
        else if (ctl.insert && gt)
        begin
            entry_next = prev_gt ? prev_entry : new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end
endmodule

// File: design/stt_chain.sv
// row of cells that keeps entries sorted by column and drains from the head
`timescale 1ns / 1ps
module stt_chain
    import stt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stt_ctrl_t  ctl,
    input  stt_entry_t new_entry,
    output stt_entry_t head,
    output logic       second_vld
);
    stt_entry_t cell_q [MAX_ENTRIES];
    logic       gt_q   [MAX_ENTRIES];

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        stt_entry_t prev_e;
        stt_entry_t next_e;
        logic       prev_g;

        if (i == 0)
        begin : g_first
            assign prev_e = '0;
            assign prev_g = 1'b0;
        end
        else
        begin : g_mid
            assign prev_e = cell_q[i-1];
            assign prev_g = gt_q[i-1];
        end

        if (i == MAX_ENTRIES - 1)
        begin : g_last
            assign next_e = '0;
        end
        else
        begin : g_inner
            assign next_e = cell_q[i+1];
        end

        stt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .new_entry  (new_entry),
            .prev_entry (prev_e),
            .prev_gt    (prev_g),
            .next_entry (next_e),
            .entry      (cell_q[i]),
            .gt         (gt_q[i])
        );
    end

    assign head = cell_q[0];

    if (MAX_ENTRIES > 1)
    begin : g_second
        assign second_vld = cell_q[1].vld;
    end
    else
    begin : g_single
        assign second_vld = 1'b0;
    end
endmodule

// File: design/sparse_triplet_transpose_unit.sv
// top level of the sparse triplet transpose unit
// Triples are taken one word per clock while a matrix is being loaded; each
// accepted triple with entry_valid set, in range and with room left is
// inserted in the same cycle into a 64-cell chain kept sorted by source
// column, stable within a column. After the word that carries last_entry,
// the input stalls and the n stored entries leave from the head of the
// chain, one word per clock while out_stall is low, row and column swapped;
// then the next matrix may load. A last word with nothing stored gives no
// output and does not stall the input. There is no clearing pass after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sparse_triplet_transpose_unit
    import stt_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_W-1:0]            paddr,
    input  logic [DATA_W-1:0]            pwdata,
    output logic [DATA_W-1:0]            prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         entry_valid,
    input  logic [IDX_W-1:0]             src_row,
    input  logic [IDX_W-1:0]             src_col,
    input  logic signed [VALUE_BITS-1:0] entry_value,
    input  logic                         last_entry,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [IDX_W-1:0]             out_row,
    output logic [IDX_W-1:0]             out_col,
    output logic signed [VALUE_BITS-1:0] out_value,
    output logic                         out_last,
    output logic                         overflow
);
    logic [DIM_W-1:0] num_cols_reg, num_cols_next;
    logic [DIM_W-1:0] num_rows_reg, num_rows_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             drain_reg, drain_next;
    logic             dropped_reg, dropped_next;

    logic [DIM_W-1:0] cols_eff;
    logic [DIM_W-1:0] rows_eff;
    logic             reg_wr;
    logic             accept_in;
    logic             accept_out;
    logic             in_range;
    logic             full;
    logic             do_insert;
    logic             do_drop;
    logic [CNT_W-1:0] total;
    stt_ctrl_t        ctl;
    stt_entry_t       new_entry;
    stt_entry_t       head;
    logic             second_vld;

    // register port
    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_NUM_ROWS) ? DATA_W'(num_rows_reg) : DATA_W'(num_cols_reg);

    always_comb
    begin
        num_cols_next = num_cols_reg;
        num_rows_next = num_rows_reg;
        if (reg_wr)
        begin
            unique case (paddr[2])
                REG_NUM_COLS: num_cols_next = pwdata[DIM_W-1:0];
                REG_NUM_ROWS: num_rows_next = pwdata[DIM_W-1:0];
                default:      num_cols_next = num_cols_reg;
            endcase
        end
    end

    assign cols_eff = (num_cols_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : num_cols_reg;
    assign rows_eff = (num_rows_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : num_rows_reg;

    // load side
    assign in_stall   = drain_reg;
    assign accept_in  = in_valid && !in_stall;
    assign in_range   = (DIM_W'(src_row) < rows_eff) && (DIM_W'(src_col) < cols_eff);
    assign full       = (count_reg == CNT_W'(MAX_ENTRIES));
    assign do_insert  = accept_in && entry_valid && in_range && !full;
    assign do_drop    = accept_in && entry_valid && !(in_range && !full);
    assign total      = count_reg + CNT_W'(do_insert);

    assign new_entry.vld = 1'b1;
    assign new_entry.col = src_col;
    assign new_entry.row = src_row;
    assign new_entry.val = entry_value;

    // drain side
    assign out_valid  = drain_reg && head.vld;
    assign accept_out = out_valid && !out_stall;
    assign out_row    = head.col;
    assign out_col    = head.row;
    assign out_value  = head.val;
    assign out_last   = !second_vld;
    assign overflow   = dropped_reg;

    assign ctl.insert = do_insert;
    assign ctl.shift  = accept_out;

    stt_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .new_entry  (new_entry),
        .head       (head),
        .second_vld (second_vld)
    );

    always_comb
    begin
        count_next   = total;
        drain_next   = drain_reg;
        dropped_next = dropped_reg || do_drop;
        priority if (accept_out && out_last)
        begin
            count_next   = '0;
            drain_next   = 1'b0;
            dropped_next = 1'b0;
        end
        else if (accept_in && last_entry)
        begin
            if (total == '0)
            begin
                dropped_next = 1'b0;
            end
            else
            begin
                drain_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= DIM_W'(MAX_DIM);
            num_rows_reg <= DIM_W'(MAX_DIM);
            count_reg    <= '0;
            drain_reg    <= 1'b0;
            dropped_reg  <= 1'b0;
        end
        else
        begin
            num_cols_reg <= num_cols_next;
            num_rows_reg <= num_rows_next;
            count_reg    <= count_next;
            drain_reg    <= drain_next;
            dropped_reg  <= dropped_next;
        end
    end

    `ASSERT_PROP(a_head_sorted, clk, rst_n, (head.vld && second_vld) |-> (head.col <= u_chain.cell_q[1].col))
    `ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > CNT_W'(MAX_ENTRIES))
    `ASSERT_NEVER(a_drain_empty, clk, rst_n, drain_reg && !head.vld)
    `ASSERT_PROP(a_last_ends, clk, rst_n, (accept_out && out_last) |=> !out_valid)
endmodule

// File: sim/sparse_triplet_transpose_unit_tb.sv
// testbench of the sparse triplet transpose unit against a transpose predictor
`timescale 1ns / 1ps
module sparse_triplet_transpose_unit_tb;
    import stt_pkg::*;

    localparam int CYCLE_LIMIT = 100000;

    typedef struct {
        logic [IDX_W-1:0]             row;
        logic [IDX_W-1:0]             col;
        logic signed [VALUE_BITS-1:0] value;
        logic                         last;
        logic                         ovf;
    } transposed_word_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [ADDR_W-1:0]            paddr;
    logic [DATA_W-1:0]            pwdata;
    logic [DATA_W-1:0]            prdata;
    logic                         pready;
    logic                         in_valid;
    logic                         in_stall;
    logic                         entry_valid;
    logic [IDX_W-1:0]             src_row;
    logic [IDX_W-1:0]             src_col;
    logic signed [VALUE_BITS-1:0] entry_value;
    logic                         last_entry;
    logic                         out_valid;
    logic                         out_stall;
    logic [IDX_W-1:0]             out_row;
    logic [IDX_W-1:0]             out_col;
    logic signed [VALUE_BITS-1:0] out_value;
    logic                         out_last;
    logic                         overflow;

    // predictor state
    logic [IDX_W-1:0]             held_row [MAX_ENTRIES];
    logic [IDX_W-1:0]             held_col [MAX_ENTRIES];
    logic signed [VALUE_BITS-1:0] held_val [MAX_ENTRIES];
    int                           held_count;
    logic                         held_dropped;
    logic [6:0]                   cfg_cols;
    logic [6:0]                   cfg_rows;
    transposed_word_t             transposed_q[$];

    int                           error_count;
    bit                           gaps_on;
    int                           hold_left;
    int                           burst_left;

    sparse_triplet_transpose_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .entry_valid (entry_valid),
        .src_row     (src_row),
        .src_col     (src_col),
        .entry_value (entry_value),
        .last_entry  (last_entry),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_value   (out_value),
        .out_last    (out_last),
        .overflow    (overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int eff_dim(input logic [6:0] dim);
        return (dim > MAX_DIM) ? MAX_DIM : int'(dim);
    endfunction

    task automatic track_triple(input logic ev, input logic [IDX_W-1:0] r,
                                input logic [IDX_W-1:0] c,
                                input logic signed [VALUE_BITS-1:0] v, input logic lst);
        transposed_word_t w;
        int               k;
        if (ev)
        begin
            if (r >= eff_dim(cfg_rows) || c >= eff_dim(cfg_cols) || held_count >= MAX_ENTRIES)
                held_dropped = 1'b1;
            else
            begin
                held_row[held_count] = r;
                held_col[held_count] = c;
                held_val[held_count] = v;
                held_count++;
            end
        end
        if (lst)
        begin
            k = 0;
            for (int col = 0; col < MAX_DIM; col++)
            begin
                for (int i = 0; i < held_count; i++)
                begin
                    if (held_col[i] == col)
                    begin
                        k++;
                        w.row   = held_col[i];
                        w.col   = held_row[i];
                        w.value = held_val[i];
                        w.last  = (k == held_count);
                        w.ovf   = held_dropped;
                        transposed_q.insert(transposed_q.size(), w);
                    end
                end
            end
            held_count   = 0;
            held_dropped = 1'b0;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        transposed_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (transposed_q.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected word: row %0d col %0d value %0d last %0b ovf %0b",
                             out_row, out_col, out_value, out_last, overflow);
            end
            else
            begin
                w = transposed_q.pop_front();
                if (out_row !== w.row || out_col !== w.col || out_value !== w.value ||
                    out_last !== w.last || overflow !== w.ovf)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: exp %0d %0d %0d %0b %0b, got %0d %0d %0d %0b %0b",
                                 w.row, w.col, w.value, w.last, w.ovf,
                                 out_row, out_col, out_value, out_last, overflow);
                end
            end
        end
    end

    // receiver stall: a long hold-off when one is set, else random bursts while gaps are on
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (burst_left > 0)
        begin
            burst_left--;
            out_stall <= 1'b1;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            burst_left = $urandom_range(0, 14);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[sparse_triplet_transpose_unit] ERROR");
        $finish;
    end

    task automatic send_word(input logic ev, input logic [IDX_W-1:0] r,
                             input logic [IDX_W-1:0] c,
                             input logic signed [VALUE_BITS-1:0] v, input logic lst);
        entry_valid <= ev;
        src_row     <= r;
        src_col     <= c;
        entry_value <= v;
        last_entry  <= lst;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        track_triple(ev, r, c, v, lst);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (transposed_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_dim(input logic idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_NUM_COLS)
            cfg_cols = data[6:0];
        else
            cfg_rows = data[6:0];
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {{(DATA_W-7){1'b0}}, data[6:0]})
        begin
            error_count++;
            if (error_count <= 10)
                $display("register %0d readback: exp %0d got %0d", idx, data[6:0], prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_dims(input logic [DATA_W-1:0] cols, input logic [DATA_W-1:0] rows);
        wait_drained();
        write_dim(REG_NUM_COLS, cols);
        write_dim(REG_NUM_ROWS, rows);
    endtask

    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(input logic [6:0] dim);
        int lim;
        lim = (dim == 0) ? MAX_DIM : eff_dim(dim);
        if ($urandom_range(0, 9) == 0)
            return IDX_W'($urandom_range(0, MAX_DIM - 1));
        return IDX_W'($urandom_range(0, lim - 1));
    endfunction

    task automatic send_random_matrix(input int size, input int valid_pct);
        for (int i = 0; i < size; i++)
            send_word($urandom_range(1, 100) <= valid_pct, pick_index(cfg_rows),
                      pick_index(cfg_cols), pick_value(), i == size - 1);
    endtask

    task automatic test_corner_values();
        send_word(1'b1, 6'd0, 6'd0, 32'sh8000_0000, 1'b0);
        send_word(1'b1, 6'd63, 6'd63, 32'sh7FFF_FFFF, 1'b0);
        send_word(1'b1, 6'd0, 6'd63, -32'sd1, 1'b0);
        send_word(1'b1, 6'd63, 6'd0, 32'sd0, 1'b0);
        send_word(1'b0, 6'd21, 6'd42, 32'sh5555_AAAA, 1'b0);
        send_word(1'b1, 6'd42, 6'd21, 32'shAAAA_5555, 1'b1);
    endtask

    task automatic test_column_order();
        send_word(1'b1, 6'd3, 6'd7, 32'sd11, 1'b0);
        send_word(1'b1, 6'd1, 6'd7, 32'sd22, 1'b0);
        send_word(1'b1, 6'd9, 6'd2, 32'sd33, 1'b0);
        send_word(1'b1, 6'd0, 6'd7, 32'sd44, 1'b0);
        send_word(1'b1, 6'd4, 6'd2, 32'sd55, 1'b1);
    endtask

    task automatic test_empty_end();
        send_word(1'b1, 6'd2, 6'd3, 32'sd123, 1'b0);
        send_word(1'b0, 6'd5, 6'd5, 32'sd9, 1'b1);
        send_word(1'b0, 6'd63, 6'd63, -32'sd9, 1'b1);
    endtask

    task automatic test_range_drop();
        set_dims(32'd4, 32'd3);
        send_word(1'b1, 6'd2, 6'd3, 32'sd1, 1'b0);
        send_word(1'b1, 6'd3, 6'd0, 32'sd2, 1'b0);
        send_word(1'b1, 6'd0, 6'd4, 32'sd3, 1'b0);
        send_word(1'b1, 6'd63, 6'd63, 32'sd4, 1'b0);
        send_word(1'b1, 6'd1, 6'd1, 32'sd5, 1'b1);
        send_word(1'b1, 6'd3, 6'd3, 32'sd6, 1'b1);
        send_word(1'b1, 6'd0, 6'd0, 32'sd7, 1'b1);
    endtask

    task automatic test_dim_limits();
        set_dims(32'd0, 32'd0);
        send_word(1'b1, 6'd0, 6'd0, 32'sd8, 1'b1);
        set_dims(32'd127, 32'hFFFF_FFC1);
        send_word(1'b1, 6'd63, 6'd63, -32'sd8, 1'b1);
        set_dims(32'd1, 32'd1);
        send_word(1'b1, 6'd0, 6'd0, 32'sd9, 1'b0);
        send_word(1'b1, 6'd0, 6'd1, 32'sd10, 1'b1);
    endtask

    task automatic test_capacity();
        set_dims(32'd64, 32'd64);
        send_random_matrix(68, 100);
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_left = 250;
        send_random_matrix(10, 95);
        send_random_matrix(8, 95);
    endtask

    task automatic test_random_matrices();
        int sent;
        int size;
        sent = 0;
        while (sent < 10)
        begin
            if ($urandom_range(0, 2) == 0)
                set_dims($urandom_range(0, 3) == 0 ? 32'd64 : $urandom_range(1, 64),
                         $urandom_range(0, 3) == 0 ? 32'd1 : $urandom_range(1, 64));
            gaps_on = ($urandom_range(0, 3) != 0);
            size = $urandom_range(1, 6);
            send_random_matrix(size, 90);
            sent += size;
        end
    endtask

    task automatic test_quiet_tail();
        set_dims(32'd16, 32'd16);
        gaps_on = 1'b0;
        send_random_matrix(6, 90);
        send_random_matrix(6, 90);
        wait_drained();
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_valid    <= 1'b0;
        entry_valid <= 1'b0;
        src_row     <= '0;
        src_col     <= '0;
        entry_value <= '0;
        last_entry  <= 1'b0;
        held_count   = 0;
        held_dropped = 1'b0;
        cfg_cols     = 7'd64;
        cfg_rows     = 7'd64;
        error_count  = 0;
        gaps_on      = 1'b1;
        hold_left    = 0;
        burst_left   = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_corner_values();
        test_column_order();
        test_empty_end();
        test_range_drop();
        test_dim_limits();
        test_capacity();
        test_backpressure();
        test_random_matrices();
        test_quiet_tail();

        repeat (20) @(negedge clk);
        if (error_count == 0 && transposed_q.size() == 0)
            $display("[sparse_triplet_transpose_unit] OK");
        else
            $display("[sparse_triplet_transpose_unit] ERROR");
        $finish;
    end
endmodule
